// ===== sv/h2ws_pkg.sv =====
package h2ws_pkg;

   localparam int CordicStepsDefault = 16;
   localparam int SpeedBitsDefault   = 16;

   localparam int CfgW  = 15;
   localparam int InW   = 16;
   localparam int OutW  = 17;
   localparam int CordW = 44;
   localparam int ZW    = 24;
   localparam int AngW  = 15;
   localparam int LenW  = 17;
   localparam int PrdW  = LenW + AngW;
   localparam int DeltaW = PrdW + 1;
   localparam int SpdW  = 19;

   localparam logic [ZW-1:0] PiQ20 = 24'd3294199;
   localparam logic [AngW-1:0] PiQ13 = 15'd25736;

   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_SOFT = 2'd1;
   localparam logic [1:0] MODE_HARD = 2'd2;

   localparam logic [1:0] REG_HARD = 2'd0;
   localparam logic [1:0] REG_SOFT = 2'd1;
   localparam logic [1:0] REG_NONE = 2'd2;
   localparam logic [1:0] REG_MAX  = 2'd3;

   typedef struct packed {
      logic signed [CordW-1:0] x;
      logic signed [CordW-1:0] y;
      logic signed [ZW-1:0]    z;
   } cord_type;

   function automatic logic [ZW-1:0] atan_q20(input logic [4:0] i);
      logic [ZW-1:0] t;
      begin
         case (i)
            5'd0: t = 24'd823550;
            5'd1: t = 24'd486170;
            5'd2: t = 24'd256879;
            5'd3: t = 24'd130396;
            5'd4: t = 24'd65451;
            5'd5: t = 24'd32757;
            5'd6: t = 24'd16383;
            5'd7: t = 24'd8192;
            5'd8: t = 24'd4096;
            5'd9: t = 24'd2048;
            5'd10: t = 24'd1024;
            5'd11: t = 24'd512;
            5'd12: t = 24'd256;
            5'd13: t = 24'd128;
            5'd14: t = 24'd64;
            5'd15: t = 24'd32;
            5'd16: t = 24'd16;
            5'd17: t = 24'd8;
            5'd18: t = 24'd4;
            5'd19: t = 24'd2;
            5'd20: t = 24'd1;
            default: t = '0;
         endcase
         return t;
      end
   endfunction

endpackage

// ===== sv/h2ws_cell.sv =====
module h2ws_cell #(
   parameter int Shift = 0
) (
   input  logic                clock,
   input  h2ws_pkg::cord_type  cord_in,
   output h2ws_pkg::cord_type  cord_out
);
   import h2ws_pkg::*;

   cord_type cord_ff;
   cord_type cord_in_w;
   logic signed [CordW-1:0] xs;
   logic signed [CordW-1:0] ys;

   always_comb begin
      xs = cord_in.x >>> Shift;
      ys = cord_in.y >>> Shift;
      cord_in_w = cord_in;
      if (!cord_in.y[CordW-1]) begin
         cord_in_w.x = cord_in.x + ys;
         cord_in_w.y = cord_in.y - xs;
         cord_in_w.z = cord_in.z + atan_q20(5'(Shift));
      end else begin
         cord_in_w.x = cord_in.x - ys;
         cord_in_w.y = cord_in.y + xs;
         cord_in_w.z = cord_in.z - atan_q20(5'(Shift));
      end
   end

   always_ff @(posedge clock) begin
      cord_ff <= cord_in_w;
   end

   assign cord_out = cord_ff;
endmodule

// ===== sv/h2ws_sqrt.sv =====
module h2ws_sqrt (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [2*h2ws_pkg::LenW-1:0]  radicand,
   output logic                         done,
   output logic [h2ws_pkg::LenW-1:0]    root
);
   import h2ws_pkg::*;

   localparam int RW = 2 * LenW;

   logic [RW-1:0] rem_ff, rem_in;
   logic [RW-1:0] res_ff, res_in;
   logic [RW-1:0] bit_ff, bit_in;
   logic          busy_ff, busy_in;

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = {2'b01, {(RW-2){1'b0}}};
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_ff >= res_ff + bit_ff) begin
            rem_in = rem_ff - (res_ff + bit_ff);
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0] || bit_ff[1]) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   // done marks the last step; the root it finishes is the next value
   assign done = busy_ff && !busy_in && !start;
   assign root = res_in[LenW-1:0];
endmodule

// ===== sv/h2ws_div.sv =====
module h2ws_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [h2ws_pkg::PrdW-1:0]   dividend,
   input  logic [h2ws_pkg::CfgW-1:0]   divisor,
   output logic                        done,
   output logic [h2ws_pkg::PrdW-1:0]   quotient
);
   import h2ws_pkg::*;

   localparam int CntW = $clog2(PrdW + 1);

   logic [PrdW-1:0] q_ff, q_in;
   logic [CfgW:0]   r_ff, r_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [CfgW+1:0] trial;

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      trial = {r_ff, q_ff[PrdW-1]};
      if (start) begin
         q_in = dividend;
         r_in = '0;
         cnt_in = CntW'(PrdW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {2'b00, divisor}) begin
            r_in = (CfgW+1)'(trial - {2'b00, divisor});
            q_in = {q_ff[PrdW-2:0], 1'b1};
         end else begin
            r_in = trial[CfgW:0];
            q_in = {q_ff[PrdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      cnt_ff <= cnt_in;
   end

   assign done = busy_ff && !busy_in && !start;
   assign quotient = q_ff;
endmodule

// ===== sv/heading_to_wheel_speeds.sv =====
// Differential-drive wheel speeds from a heading vector.
//
// Input channel req_ (valid/stall) carries a Q8.8 heading (x, y). Output
// channel rsp_ carries left/right wheel speeds (Q8.8, 17 bit signed) and the
// turn mode after the update (0 none, 1 soft, 2 hard). One transaction out per
// transaction in.
// One heading is processed at a time. The CORDIC chain (one registered cell
// per step, CORDIC_STEPS capped by Steps) runs first, then the 17-step square
// root, a mode state, a product state and a 32-step restoring division.
// rsp_valid rises at the edge that leaves the output state and req_stall
// drops at the same edge, so a new heading is taken only once the previous
// one has reached the output register. The output register holds while
// rsp_stall is high; the next heading may already be in work meanwhile and
// waits for the register before it finishes.
// Reset (synchronous, active high) restores threshold and speed registers
// to their defaults and the turn mode to none, and empties the pipeline.
// The csr_ port writes registers 0..3 (hard, soft, none thresholds, max
// speed); write only while idle.
module heading_to_wheel_speeds #(
   parameter int CORDIC_STEPS = h2ws_pkg::CordicStepsDefault,
   parameter int SPEED_BITS   = h2ws_pkg::SpeedBitsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [h2ws_pkg::InW-1:0]   req_heading_x,
   input  logic signed [h2ws_pkg::InW-1:0]   req_heading_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [h2ws_pkg::OutW-1:0]  rsp_left_speed,
   output logic signed [h2ws_pkg::OutW-1:0]  rsp_right_speed,
   output logic [1:0]                        rsp_turn_mode,
   input  logic                              csr_write,
   input  logic [1:0]                        csr_index,
   input  logic [h2ws_pkg::CfgW-1:0]         csr_data
);
   import h2ws_pkg::*;

   localparam int Steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int CntW  = $clog2(Steps + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_MODE  = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [CfgW-1:0] hard_ff, soft_ff, none_ff, max_ff;
   logic [1:0]      mode_ff, mode_in;
   logic [2:0]      st_ff, st_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            sq_seen_ff, sq_seen_in;

   logic signed [InW-1:0] x_ff, y_ff;
   logic [LenW-1:0]  len_ff;
   logic signed [AngW:0] ang_ff, ang_in;
   logic [AngW-1:0]  a_ff;
   logic [LenW-1:0]  base_ff;

   logic                    rsp_valid_ff;
   logic signed [OutW-1:0]  left_ff, right_ff;
   logic [1:0]              tmode_ff;

   cord_type chain [0:Steps];
   cord_type seed;

   logic req_fire, rsp_free;
   logic [2*LenW-1:0] radicand;
   logic sq_done, div_done;
   logic [LenW-1:0] sq_root;
   logic [PrdW-1:0] quot;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (st_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;

   // Seed: fold left half-plane onto the right
   always_comb begin
      logic signed [CordW-1:0] xe, ye;
      xe = CordW'(req_heading_x) <<< 24;
      ye = CordW'(req_heading_y) <<< 24;
      seed.z = '0;
      if (req_heading_x[InW-1]) begin
         seed.x = -xe;
         seed.y = -ye;
         seed.z = req_heading_y[InW-1] ? -PiQ20 : PiQ20;
      end else begin
         seed.x = xe;
         seed.y = ye;
      end
   end

   always_ff @(posedge clock) begin
      chain[0] <= seed;
   end

   for (genvar g = 0; g < Steps; g++) begin : g_cell
      h2ws_cell #(.Shift(g)) u_cell (
         .clock   (clock),
         .cord_in (chain[g]),
         .cord_out(chain[g+1])
      );
   end

   assign radicand = (2*LenW)'(unsigned'(32'(x_ff * x_ff)))
                     + (2*LenW)'(unsigned'(32'(y_ff * y_ff)));

   logic sq_start;
   assign sq_start = (st_ff == ST_RUN) && (cnt_ff == '0) && !sq_seen_ff;

   h2ws_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .radicand(radicand),
      .done    (sq_done),
      .root    (sq_root)
   );

   // Product plus half divisor; the divider registers it as it starts
   logic [PrdW-1:0] prod_w;
   assign prod_w = PrdW'(base_ff * a_ff) + PrdW'(hard_ff >> 1);

   logic div_start;
   assign div_start = (st_ff == ST_MUL);

   h2ws_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(prod_w),
      .divisor (hard_ff),
      .done    (div_done),
      .quotient(quot)
   );

   // Angle from the chain end
   always_comb begin
      logic signed [ZW-1:0] zr;
      logic signed [ZW-1:0] zf;
      zf = chain[Steps].z;
      zr = (zf + ZW'(64)) >>> 7;
      if (y_ff == '0) begin
         ang_in = x_ff[InW-1] ? (AngW+1)'(PiQ13) : '0;
      end else if (zr > $signed(ZW'(PiQ13))) begin
         ang_in = (AngW+1)'(PiQ13);
      end else if (zr < -$signed(ZW'(PiQ13))) begin
         ang_in = -(AngW+1)'(PiQ13);
      end else begin
         ang_in = zr[AngW:0];
      end
   end

   always_comb begin
      logic [AngW-1:0] a;
      a = ang_ff[AngW] ? AngW'(-ang_ff) : ang_ff[AngW-1:0];
      mode_in = mode_ff;
      if (a <= none_ff) mode_in = MODE_NONE;
      else if (a > hard_ff) mode_in = MODE_HARD;
      else if (mode_ff == MODE_NONE && a > soft_ff) mode_in = MODE_SOFT;
   end

   always_comb begin
      st_in = st_ff;
      cnt_in = cnt_ff;
      sq_seen_in = sq_seen_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               st_in = ST_RUN;
               cnt_in = CntW'(Steps);
               sq_seen_in = 1'b0;
            end
         end
         ST_RUN: begin
            if (cnt_ff != '0) cnt_in = cnt_ff - 1'b1;
            if (sq_start) sq_seen_in = 1'b1;
            if (sq_done) st_in = ST_MODE;
         end
         ST_MODE: st_in = ST_MUL;
         ST_MUL:  st_in = ST_DIV;
         ST_DIV:  if (div_done) st_in = ST_OUT;
         ST_OUT:  if (rsp_free) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // Speeds
   logic signed [SpdW-1:0] s1, s2, lft, rgt;
   logic [PrdW-1:0] delta;
   always_comb begin
      delta = (hard_ff == '0) ? '0 : quot;
      unique case (mode_ff)
         MODE_SOFT: begin
            s1 = SpdW'(base_ff) - SpdW'(delta);
            s2 = SpdW'(base_ff) + SpdW'(delta);
         end
         MODE_HARD: begin
            s1 = -SpdW'(max_ff);
            s2 = SpdW'(max_ff);
         end
         default: begin
            s1 = SpdW'(base_ff);
            s2 = SpdW'(base_ff);
         end
      endcase
      if (!ang_ff[AngW] && ang_ff != '0) begin
         lft = s1;
         rgt = s2;
      end else begin
         lft = s2;
         rgt = s1;
      end
   end

   function automatic logic signed [OutW-1:0] sat(input logic signed [SpdW-1:0] v);
      logic signed [SpdW+16:0] hi, lo, w;
      begin
         hi = (SpdW+17)'((64'sd1 <<< SPEED_BITS) - 1);
         lo = -(SpdW+17)'(64'sd1 <<< SPEED_BITS);
         w  = (SpdW+17)'(v);
         if (w > hi) w = hi;
         if (w < lo) w = lo;
         return w[OutW-1:0];
      end
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         mode_ff <= MODE_NONE;
         rsp_valid_ff <= 1'b0;
         hard_ff <= 15'd12868;
         soft_ff <= 15'd6434;
         none_ff <= 15'd1430;
         max_ff <= 15'd2560;
         cnt_ff <= '0;
         sq_seen_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         cnt_ff <= cnt_in;
         sq_seen_ff <= sq_seen_in;
         if (st_ff == ST_MODE) mode_ff <= mode_in;
         if (st_ff == ST_OUT && rsp_free) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               REG_HARD: hard_ff <= csr_data;
               REG_SOFT: soft_ff <= csr_data;
               REG_NONE: none_ff <= csr_data;
               REG_MAX:  max_ff  <= csr_data;
               default: ;
            endcase
         end
      end
      if (req_fire) begin
         x_ff <= req_heading_x;
         y_ff <= req_heading_y;
      end
      if (st_ff == ST_RUN && cnt_ff == '0 && sq_seen_ff == 1'b0) ang_ff <= ang_in;
      if (sq_done) len_ff <= sq_root;
      if (st_ff == ST_MODE) begin
         a_ff <= ang_ff[AngW] ? AngW'(-ang_ff) : ang_ff[AngW-1:0];
         base_ff <= (len_ff < LenW'(max_ff)) ? len_ff : LenW'(max_ff);
      end
      if (st_ff == ST_OUT && rsp_free) begin
         left_ff <= sat(lft);
         right_ff <= sat(rgt);
         tmode_ff <= mode_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_left_speed = left_ff;
   assign rsp_right_speed = right_ff;
   assign rsp_turn_mode = tmode_ff;
endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import h2ws_pkg::*;

   localparam longint PI_Z20 = 3294199;
   localparam longint PI_A13 = 25736;
   localparam int MAX_SHOWN = 10;

   typedef struct {
      logic signed [15:0] hx;
      logic signed [15:0] hy;
   } heading_type;

   typedef struct {
      logic signed [16:0] left;
      logic signed [16:0] right;
      logic [1:0]         mode;
   } wheels_type;

   localparam longint ATAN_Q20 [16] = '{
      823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
      4096, 2048, 1024, 512, 256, 128, 64, 32
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [15:0] req_heading_x = '0;
   logic signed [15:0] req_heading_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [16:0] rsp_left_speed;
   logic signed [16:0] rsp_right_speed;
   logic [1:0] rsp_turn_mode;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = '0;
   logic [14:0] csr_data = '0;

   heading_to_wheel_speeds DUT (.*);

   heading_type pending_q[$];
   wheels_type  wheels_q[$];

   // shadow of the block's registers and turn mode
   longint hard_thr, soft_thr, none_thr, speed_cap;
   logic [1:0] mode_q;

   int  mismatches = 0;
   bit  idle_on = 1'b1;
   bit  hold_req = 1'b0;
   bit  req_taken = 1'b0;
   int  send_gap = 0;
   int  stall_gap = 0;
   int  hold_cnt = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic longint sqrt_floor(input longint v);
      longint res;
      longint t;
      res = 0;
      for (int b = 16; b >= 0; b--) begin
         t = res | (longint'(1) << b);
         if (t * t <= v) res = t;
      end
      return res;
   endfunction

   function automatic longint heading_angle_q13(input longint hx, input longint hy);
      longint x, y, z, xs, ys, r;
      x = hx;
      y = hy;
      z = 0;
      if (y == 0) return (x < 0) ? PI_A13 : 0;
      if (x < 0) begin
         z = (y >= 0) ? PI_Z20 : -PI_Z20;
         x = -x;
         y = -y;
      end
      x = x * 16777216;
      y = y * 16777216;
      for (int i = 0; i < 16; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_Q20[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_Q20[i];
         end
      end
      r = (z + 64) >>> 7;
      if (r > PI_A13) r = PI_A13;
      if (r < -PI_A13) r = -PI_A13;
      return r;
   endfunction

   function automatic logic signed [16:0] clamp_speed(input longint v);
      if (v > 65535) return 17'sd65535;
      if (v < -65536) return -17'sd65536;
      return v[16:0];
   endfunction

   function automatic wheels_type predict_wheels(input heading_type h);
      longint ang, a, len, base, delta, s1, s2;
      wheels_type w;
      ang = heading_angle_q13(h.hx, h.hy);
      a = (ang < 0) ? -ang : ang;
      len = sqrt_floor(longint'(h.hx) * h.hx + longint'(h.hy) * h.hy);
      base = (len < speed_cap) ? len : speed_cap;
      if (a <= none_thr) mode_q = MODE_NONE;
      else if (a > hard_thr) mode_q = MODE_HARD;
      else if (mode_q == MODE_NONE && a > soft_thr) mode_q = MODE_SOFT;
      if (mode_q == MODE_SOFT) begin
         delta = (hard_thr != 0) ? (base * a + hard_thr / 2) / hard_thr : 0;
         s1 = base - delta;
         s2 = base + delta;
      end else if (mode_q == MODE_HARD) begin
         s1 = -speed_cap;
         s2 = speed_cap;
      end else begin
         s1 = base;
         s2 = base;
      end
      w.left  = clamp_speed((ang > 0) ? s1 : s2);
      w.right = clamp_speed((ang > 0) ? s2 : s1);
      w.mode  = mode_q;
      return w;
   endfunction

   // input side: predict on acceptance
   always @(posedge clock) begin
      heading_type h;
      req_taken = 1'b0;
      if (!reset && req_valid && !req_stall) begin
         h.hx = req_heading_x;
         h.hy = req_heading_y;
         wheels_q = {wheels_q, predict_wheels(h)};
         req_taken = 1'b1;
      end
   end

   // output side: compare against the oldest expected transaction
   always @(posedge clock) begin
      wheels_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wheels_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("unexpected transaction: left %0d right %0d mode %0d",
                        rsp_left_speed, rsp_right_speed, rsp_turn_mode);
         end else begin
            w = wheels_q.pop_front();
            if (w.left !== rsp_left_speed || w.right !== rsp_right_speed ||
                w.mode !== rsp_turn_mode) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("mismatch: expected L %0d R %0d M %0d, got L %0d R %0d M %0d",
                           w.left, w.right, w.mode,
                           rsp_left_speed, rsp_right_speed, rsp_turn_mode);
            end
         end
      end
   end

   // driver
   always @(negedge clock) begin
      heading_type h;
      if (!reset && !(req_valid && !req_taken)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (idle_on && pending_q.size() != 0 && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(1, 11) - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() != 0) begin
            h = pending_q.pop_front();
            req_heading_x <= h.hx;
            req_heading_y <= h.hy;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      if (hold_req) begin
         hold_req = 1'b0;
         hold_cnt = 400;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (stall_gap > 0) begin
         stall_gap--;
         rsp_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_gap = $urandom_range(1, 11) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic write_reg(input logic [1:0] idx, input int unsigned val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[14:0];
      @(negedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_HARD: hard_thr  = val[14:0];
         REG_SOFT: soft_thr  = val[14:0];
         REG_NONE: none_thr  = val[14:0];
         default:  speed_cap = val[14:0];
      endcase
   endtask

   task automatic set_thresholds(input int unsigned hard_v, soft_v, none_v, cap_v);
      write_reg(REG_HARD, hard_v);
      write_reg(REG_SOFT, soft_v);
      write_reg(REG_NONE, none_v);
      write_reg(REG_MAX, cap_v);
   endtask

   task automatic add_heading(input int hx, input int hy);
      heading_type h;
      h.hx = hx[15:0];
      h.hy = hy[15:0];
      pending_q = {pending_q, h};
   endtask

   function automatic heading_type random_heading();
      heading_type h;
      int x;
      int y;
      x = $signed(16'($urandom));
      y = $signed(16'($urandom));
      case ($urandom_range(0, 9))
         0, 1, 2: ;
         3, 4: begin
            x = $urandom_range(0, 1200) - 600;
            y = $urandom_range(0, 1200) - 600;
         end
         5: y = 0;
         6: x = 0;
         7: begin
            x = $urandom_range(1000, 32767);
            y = $urandom_range(0, x / 2) - x / 4;
            if ($urandom_range(0, 1)) x = -x;
         end
         default: begin
            case ($urandom_range(0, 4))
               0: x = -32768;
               1: x = 32767;
               2: x = -1;
               default: ;
            endcase
            case ($urandom_range(0, 4))
               0: y = -32768;
               1: y = 32767;
               2: y = 1;
               default: ;
            endcase
         end
      endcase
      h.hx = x[15:0];
      h.hy = y[15:0];
      return h;
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_valid || wheels_q.size() != 0 ||
             hold_cnt > 0);
   endtask

   task automatic random_burst(input int n);
      repeat (n) pending_q = {pending_q, random_heading()};
      wait_drained();
   endtask

   initial begin
      #15ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      hard_thr  = 12868;
      soft_thr  = 6434;
      none_thr  = 1430;
      speed_cap = 2560;
      mode_q    = MODE_NONE;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: axes, extremes, zero vector, hysteresis walk
      add_heading(0, 0);
      add_heading(32767, 0);
      add_heading(-32768, 0);
      add_heading(-1, 0);
      add_heading(0, 32767);
      add_heading(0, -32768);
      add_heading(32767, 32767);
      add_heading(-32768, -32768);
      add_heading(-32768, 1);
      add_heading(-32768, -1);
      add_heading(1, 1);
      add_heading(-1, -1);
      add_heading(256, 0);
      add_heading(256, 60);
      add_heading(256, 150);
      add_heading(256, 60);
      add_heading(256, 300);
      add_heading(256, 150);
      add_heading(256, 20);
      add_heading(256, -150);
      add_heading(256, -300);
      add_heading(-256, 300);
      add_heading(10, 10);
      wait_drained();

      // long receiver hold while the sender keeps offering
      hold_req = 1'b1;
      random_burst(60);

      set_thresholds(1, 0, 0, 0);
      random_burst(30);
      set_thresholds(25736, 25736, 25736, 32767);
      random_burst(30);
      set_thresholds(32767, 32767, 32767, 32767);
      random_burst(20);
      set_thresholds(0, 6434, 1430, 2560);
      random_burst(30);
      set_thresholds(3000, 9000, 6000, 20000);
      random_burst(30);
      set_thresholds(8000, 2000, 500, 32767);
      random_burst(40);
      repeat (3) begin
         set_thresholds($urandom_range(0, 32767), $urandom_range(0, 32767),
                        $urandom_range(0, 32767), $urandom_range(0, 32767));
         random_burst(30);
      end
      set_thresholds(12868, 6434, 1430, 2560);
      idle_on = 1'b0;
      random_burst(60);

      repeat (100) @(posedge clock);
      if (mismatches == 0 && wheels_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/h2ws_pkg.sv
sv/h2ws_cell.sv
sv/h2ws_sqrt.sv
sv/h2ws_div.sv
sv/heading_to_wheel_speeds.sv
tb/tb_top.sv
